// ===== rtl/paerl_pkg.sv =====
package paerl_pkg;

    localparam int unsigned LIMIT_W         = 14;
    localparam int unsigned LIMIT_US_W      = 24;
    localparam int unsigned ADDR_W          = 32;
    localparam int unsigned SEC_W           = 32;
    localparam int unsigned USEC_W          = 20;
    localparam int unsigned DEF_TABLE_ENTRIES = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd1000;
    localparam logic [9:0]         USEC_PER_MS = 10'd1000;
    localparam logic [25:0]        ONE_MILLION = 26'd1000000;

    localparam logic FUNC_REPORT = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [SEC_W-1:0]  time_sec;
        logic [USEC_W-1:0] time_usec;
    } t_in_beat;

    typedef struct packed {
        logic allowed;
        logic not_stored;
    } t_out_beat;

    typedef struct packed {
        logic              clear;
        logic              update;
        logic              insert;
        logic [ADDR_W-1:0] address;
        logic [SEC_W-1:0]  time_sec;
        logic [USEC_W-1:0] time_usec;
    } t_tbl_wr;

    typedef struct packed {
        logic              hit;
        logic              full;
        logic [SEC_W-1:0]  last_sec;
        logic [USEC_W-1:0] last_usec;
    } t_tbl_rd;

endpackage

// ===== rtl/paerl_spacing.sv =====
module paerl_spacing
    import paerl_pkg::*;
(
    input  logic [SEC_W-1:0]   i_now_sec,
    input  logic [USEC_W-1:0]  i_now_usec,
    input  logic [SEC_W-1:0]   i_last_sec,
    input  logic [USEC_W-1:0]  i_last_usec,
    input  logic [LIMIT_W-1:0] i_limit_ms,
    output logic               o_ok
);

    logic [SEC_W-1:0]      ds;
    logic                  backwards;
    logic signed [25:0]    gap;
    logic signed [25:0]    gap_wrap;
    logic signed [25:0]    lim;
    logic [LIMIT_US_W-1:0] lim_us;

    assign backwards = i_now_sec < i_last_sec;
    assign ds        = i_now_sec - i_last_sec;
    assign lim_us    = LIMIT_US_W'(i_limit_ms) * LIMIT_US_W'(USEC_PER_MS);
    assign lim       = $signed({2'b00, lim_us});
    assign gap       = $signed({6'd0, i_now_usec}) - $signed({6'd0, i_last_usec});
    assign gap_wrap  = gap + $signed(ONE_MILLION);

    always_comb begin
        if (backwards) begin
            o_ok = 1'b0;
        end else if (ds > SEC_W'(1)) begin
            o_ok = 1'b1;
        end else if (ds == SEC_W'(1)) begin
            o_ok = gap_wrap > lim;
        end else begin
            o_ok = gap > lim;
        end
    end

endmodule

// ===== rtl/paerl_table.sv =====
module paerl_table
    import paerl_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_lookup,
    input  t_tbl_wr           i_wr,
    output t_tbl_rd           o_rd
);

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0]        r_addr [TABLE_ENTRIES];
    logic [SEC_W-1:0]         r_sec  [TABLE_ENTRIES];
    logic [USEC_W-1:0]        r_usec [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] hit_oh;
    logic [TABLE_ENTRIES-1:0] free_oh;

    // lowest clear bit of the valid vector
    assign free_oh = ~r_valid & (r_valid + TABLE_ENTRIES'(1));

    always_comb begin
        o_rd.last_sec  = '0;
        o_rd.last_usec = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_oh[i] = r_valid[i] && (r_addr[i] == i_lookup);
            if (hit_oh[i]) begin
                o_rd.last_sec  = o_rd.last_sec | r_sec[i];
                o_rd.last_usec = o_rd.last_usec | r_usec[i];
            end
        end
        o_rd.hit  = |hit_oh;
        o_rd.full = &r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.clear) begin
            r_valid <= '0;
        end else if (i_wr.insert) begin
            r_valid <= r_valid | free_oh;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if ((i_wr.insert && free_oh[i]) || (i_wr.update && hit_oh[i])) begin
                r_addr[i] <= i_wr.address;
                r_sec[i]  <= i_wr.time_sec;
                r_usec[i] <= i_wr.time_usec;
            end
        end
    end

endmodule

// ===== rtl/per_address_error_rate_limiter_unit.sv =====
// per-address error rate limiter
// input channel: i_in_valid / o_in_stall carry a t_in_beat (func, address,
// time_sec, time_usec); func clear empties the table, func report asks
// whether a route-error message for the address may go out now
// output channel: o_out_valid / i_out_stall carry a t_out_beat (allowed,
// not_stored), exactly one result beat for every input beat, in order
// config: i_cfg_we writes i_cfg_wdata into limit_ms; the user writes it only
// while idle, the block itself does not enforce this
// order: an accepted beat sits in the input register, is decided against the
// table and registered into the result register, which can hold on a stall
// throughput: one beat per cycle unless the output stalls, set by the parallel
// match over the entry registers and the spacing compare into the result register
// reset: table empty, limit_ms back to 1000, both channels empty
// output stall: the result register holds; the input register still takes a
// beat if it is empty, then o_in_stall rises until the result is taken
module per_address_error_rate_limiter_unit
    import paerl_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_beat           i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_beat          o_out_beat,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata
);

    logic               r_in_valid;
    t_in_beat           r_in;
    logic               r_out_valid;
    t_out_beat          r_out;
    logic [LIMIT_W-1:0] r_limit_ms;

    logic      adv;
    logic      do_step;
    logic      spacing_ok;
    t_tbl_wr   tbl_wr;
    t_tbl_rd   tbl_rd;
    t_out_beat n_out;

    assign adv         = !r_out_valid || !i_out_stall;
    assign do_step     = r_in_valid && adv;
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    paerl_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lookup(r_in.address),
        .i_wr    (tbl_wr),
        .o_rd    (tbl_rd)
    );

    paerl_spacing u_spacing (
        .i_now_sec  (r_in.time_sec),
        .i_now_usec (r_in.time_usec),
        .i_last_sec (tbl_rd.last_sec),
        .i_last_usec(tbl_rd.last_usec),
        .i_limit_ms (r_limit_ms),
        .o_ok       (spacing_ok)
    );

    always_comb begin
        tbl_wr.address   = r_in.address;
        tbl_wr.time_sec  = r_in.time_sec;
        tbl_wr.time_usec = r_in.time_usec;
        tbl_wr.clear     = 1'b0;
        tbl_wr.update    = 1'b0;
        tbl_wr.insert    = 1'b0;
        n_out.allowed    = 1'b0;
        n_out.not_stored = 1'b0;
        if (r_in.func == FUNC_CLEAR) begin
            tbl_wr.clear = do_step;
        end else if (tbl_rd.hit) begin
            n_out.allowed = spacing_ok;
            tbl_wr.update = do_step && spacing_ok;
        end else begin
            n_out.allowed    = 1'b1;
            n_out.not_stored = tbl_rd.full;
            tbl_wr.insert    = do_step && !tbl_rd.full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit_ms  <= LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit_ms <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_beat;
        end
        if (do_step) begin
            r_out <= n_out;
        end
    end

    a_not_stored_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.not_stored |-> o_out_beat.allowed)
        else $error("not_stored without allowed");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && r_in_valid)
        else $error("input stalled with empty result register");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("held input beat lost");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_step && r_in.func == FUNC_CLEAR |=> !r_out.allowed && !r_out.not_stored)
        else $error("clear beat gave a nonzero result");

endmodule
